@@ rtl/lus_pkg.sv @@
// ----------------------------------------------------------------------------
// Least-used slot selector package
// Operation and status codes, plus the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package lus_pkg;

  // Operation codes carried on the input channel.
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_ACQUIRE = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_RESET   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // Status codes carried on the result channel.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;
  localparam logic [1:0] STAT_SAT   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic lookup;   // An input transfer happens; capture the lookup.
    logic commit;   // Apply the list update and load the result register.
  } lus_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free; // The result register can take a new result this cycle.
  } lus_stat_t;

endpackage

@@ rtl/least_used_slot_selector.sv @@
// ----------------------------------------------------------------------------
// Least-used slot selector
// Keeps entry indices in a list sorted by use count and hands out the least
// used entry; supports add, acquire, release, reset counts and clear.
// ----------------------------------------------------------------------------
// Sequence: the lookup is captured at the input transfer, then the move over
// the row of list cells commits the update and loads the result register.
// No new item is taken until that commit.
// The move waits while an earlier result has not been taken.
// Reset clears the held count and the handshake state; input ready rises in the
// cycle after reset ends. List cells are only read once written, no reset.
module least_used_slot_selector import lus_pkg::*; #(
  parameter int ENTRIES    = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [4:0]  entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [4:0]  chosen_index,
  output logic [15:0] use_count,
  output logic [5:0]  entry_count
);

  lus_cmd_t  cmd;
  lus_stat_t stat;

  // Sequencer.
  lus_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // List cells and result register.
  lus_datapath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .entry_index  (entry_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .chosen_index (chosen_index),
    .use_count    (use_count),
    .entry_count  (entry_count)
  );

  // A commit never overwrites a result that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while result register is occupied");

  // After an input transfer no new item is taken until the commit.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  // An empty report always goes with an empty list.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_EMPTY) |-> (entry_count == 6'd0))
    else $error("empty status with entries held");

  // The reported entry count never exceeds the list size.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (int'(entry_count) <= ENTRIES))
    else $error("entry count beyond list size");

endmodule

@@ rtl/lus_ctrl.sv @@
// ----------------------------------------------------------------------------
// Least-used slot selector controller
// Two-state sequencer: accept an item, then commit its list update once the
// result register has room.
// ----------------------------------------------------------------------------
module lus_ctrl import lus_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lus_stat_t stat,
  output lus_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_MOVE
  } state_t;

  state_t state;

  // Commands are decoded from the current state and handshakes.
  always_comb begin
    cmd.lookup = in_valid && in_ready;
    cmd.commit = (state == ST_MOVE) && stat.out_free;
  end

  // State and the registered ready flag. Ready stays low during reset and
  // rises in the cycle after reset ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.lookup) begin
            state    <= ST_MOVE;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        ST_MOVE: begin
          if (cmd.commit) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ rtl/lus_datapath.sv @@
// ----------------------------------------------------------------------------
// Least-used slot selector datapath
// A row of list cells (entry index and use count) kept in ascending count
// order, the lookup and move logic, and the result register.
// ----------------------------------------------------------------------------
module lus_datapath import lus_pkg::*; #(
  parameter int ENTRIES    = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  lus_cmd_t    cmd,
  output lus_stat_t   stat,
  input  logic [2:0]  operation,
  input  logic [4:0]  entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [4:0]  chosen_index,
  output logic [15:0] use_count,
  output logic [5:0]  entry_count
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PLACE,
    KIND_ZERO,
    KIND_CLEAR
  } kind_t;

  // List cells, in list order; cell contents have no reset.
  logic [IDX_W-1:0]      cell_idx [ENTRIES];
  logic [COUNT_BITS-1:0] cell_cnt [ENTRIES];
  logic [CNT_W-1:0]      held;

  // Work registers captured at the input transfer.
  kind_t                 kind_r;
  logic                  drop_r;
  logic [IDX_W-1:0]      pos_r;
  logic [COUNT_BITS-1:0] val_r;
  logic [IDX_W-1:0]      new_idx_r;
  logic [CNT_W-1:0]      nrem_r;
  logic [1:0]            stat_r;

  // Lookup results.
  kind_t                 lk_kind;
  logic                  lk_drop;
  logic [IDX_W-1:0]      lk_pos;
  logic [COUNT_BITS-1:0] lk_val;
  logic [IDX_W-1:0]      lk_idx;
  logic [CNT_W-1:0]      lk_nrem;
  logic [1:0]            lk_stat;
  logic [IDX_W-1:0]      rel_pos;
  logic [COUNT_BITS-1:0] rel_cnt;
  logic [IDX_W-1:0]      req_idx;

  // Move results.
  logic [ENTRIES-1:0]    le_val;
  logic [ENTRIES-1:0]    rem_le;
  logic [IDX_W-1:0]      rem_idx [ENTRIES];
  logic [COUNT_BITS-1:0] rem_cnt [ENTRIES];
  logic [IDX_W-1:0]      mv_idx  [ENTRIES];
  logic [COUNT_BITS-1:0] mv_cnt  [ENTRIES];
  logic [CNT_W-1:0]      held_next;

  assign stat.out_free = !out_valid || out_ready;
  assign req_idx       = IDX_W'(entry_index);

  // Locate a released entry: indices of held cells are unique, so the match
  // is one-hot and an OR gathers its position and count.
  always_comb begin
    rel_pos = '0;
    rel_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (i < int'(held) && cell_idx[i] == req_idx) begin
        rel_pos = rel_pos | IDX_W'(i);
        rel_cnt = rel_cnt | cell_cnt[i];
      end
    end
  end

  // Decide what the item does and the entry that will be placed.
  always_comb begin
    lk_kind = KIND_NONE;
    lk_drop = 1'b0;
    lk_pos  = '0;
    lk_val  = '0;
    lk_idx  = '0;
    lk_nrem = held;
    lk_stat = STAT_OK;
    case (operation)
      OP_ADD: begin
        if (held == CNT_W'(ENTRIES)) begin
          lk_stat = STAT_BAD;
        end else begin
          lk_kind = KIND_PLACE;
          lk_idx  = IDX_W'(held);
        end
      end
      OP_ACQUIRE: begin
        if (held == '0) begin
          lk_stat = STAT_EMPTY;
        end else begin
          lk_kind = KIND_PLACE;
          lk_drop = 1'b1;
          lk_idx  = cell_idx[0];
          lk_nrem = held - CNT_W'(1);
          if (cell_cnt[0] == COUNT_TOP) begin
            lk_val  = COUNT_TOP;
            lk_stat = STAT_SAT;
          end else begin
            lk_val = cell_cnt[0] + COUNT_BITS'(1);
          end
        end
      end
      OP_RELEASE: begin
        if (int'(entry_index) >= int'(held)) begin
          lk_stat = STAT_BAD;
        end else begin
          lk_kind = KIND_PLACE;
          lk_drop = 1'b1;
          lk_pos  = rel_pos;
          lk_idx  = req_idx;
          lk_nrem = held - CNT_W'(1);
          if (rel_cnt == '0) begin
            lk_stat = STAT_SAT;
          end else begin
            lk_val = rel_cnt - COUNT_BITS'(1);
          end
        end
      end
      OP_RESET: lk_kind = KIND_ZERO;
      OP_CLEAR: lk_kind = KIND_CLEAR;
      default:  lk_kind = KIND_NONE;
    endcase
  end

  // Capture the lookup at the input transfer.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      kind_r    <= lk_kind;
      drop_r    <= lk_drop;
      pos_r     <= lk_pos;
      val_r     <= lk_val;
      new_idx_r <= lk_idx;
      nrem_r    <= lk_nrem;
      stat_r    <= lk_stat;
    end
  end

  // Remove the dropped cell and insert the entry behind every remaining cell
  // whose count is equal or smaller. The remaining cells stay sorted, so the
  // compare vector is a run of ones and each cell decides from its neighbors.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      le_val[i] = (i < int'(held)) && (cell_cnt[i] <= val_r);
    end
    for (int j = 0; j < ENTRIES; j++) begin
      rem_idx[j] = cell_idx[j];
      rem_cnt[j] = cell_cnt[j];
      rem_le[j]  = le_val[j];
      if (drop_r && j >= int'(pos_r) && j + 1 < ENTRIES) begin
        rem_idx[j] = cell_idx[(j + 1) % ENTRIES];
        rem_cnt[j] = cell_cnt[(j + 1) % ENTRIES];
        rem_le[j]  = le_val[(j + 1) % ENTRIES];
      end
      if (j >= int'(nrem_r)) begin
        rem_le[j] = 1'b0;
      end
    end
    for (int j = 0; j < ENTRIES; j++) begin
      if (rem_le[j]) begin
        mv_idx[j] = rem_idx[j];
        mv_cnt[j] = rem_cnt[j];
      end else if (j == 0 || rem_le[(j + ENTRIES - 1) % ENTRIES]) begin
        mv_idx[j] = new_idx_r;
        mv_cnt[j] = val_r;
      end else begin
        mv_idx[j] = rem_idx[(j + ENTRIES - 1) % ENTRIES];
        mv_cnt[j] = rem_cnt[(j + ENTRIES - 1) % ENTRIES];
      end
    end
  end

  // Number of entries held after the item.
  always_comb begin
    case (kind_r)
      KIND_PLACE: held_next = nrem_r + CNT_W'(1);
      KIND_CLEAR: held_next = '0;
      default:    held_next = held;
    endcase
  end

  // List cells.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (kind_r == KIND_PLACE) begin
          cell_idx[j] <= mv_idx[j];
          cell_cnt[j] <= mv_cnt[j];
        end else if (kind_r == KIND_ZERO) begin
          cell_cnt[j] <= '0;
        end
      end
    end
  end

  // Held count and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status      <= stat_r;
      entry_count <= 6'(held_next);
      if (kind_r == KIND_PLACE) begin
        chosen_index <= 5'(new_idx_r);
        use_count    <= 16'(val_r);
      end else begin
        chosen_index <= '0;
        use_count    <= '0;
      end
    end
  end

endmodule

@@ tb/sv/least_used_slot_selector_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-used slot selector testbench
// Drives operations over the valid/ready input channel and checks every result
// against an in-bench model of the sorted use-count list, or against the row's own
// expectation for typed rows of a short directed table that covers the error codes
// and the boundaries. A short acquire run steps one entry's count up and a release
// steps it down once. Random phases then vary the sender idling and the receiver stalling.
// ----------------------------------------------------------------------------
module least_used_slot_selector_test;
  import lus_pkg::*;

  localparam int ENTRIES     = 32;
  localparam int COUNT_BITS  = 16;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 105;

  // Operation codes that the block ignores.
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  chosen;
    logic [15:0] count;
    logic [5:0]  held;
  } selection_t;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct {
    logic [2:0]  op;
    logic [4:0]  idx;
    bit          typed;
    logic [1:0]  status;
    logic [4:0]  chosen;
    logic [15:0] count;
    logic [5:0]  held;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = OP_ADD;
  logic [4:0]  entry_index = 5'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [4:0]  chosen_index;
  logic [15:0] use_count;
  logic [5:0]  entry_count;

  // Model of the list: order of entry indices and the count per index.
  logic [4:0]  slot_order [ENTRIES];
  logic [15:0] slot_uses [ENTRIES];
  int          slots_held = 0;

  selection_t  pending_selections [$];
  selection_t  oldest_selection;
  probe_row_t  probe_rows [$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  least_used_slot_selector #(
    .ENTRIES(ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .entry_index(entry_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .chosen_index(chosen_index),
    .use_count(use_count),
    .entry_count(entry_count)
  );

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Insert entry e into a list of n entries, behind every count that is equal or smaller.
  function automatic void place_slot(input int n, input logic [4:0] e);
    int q;
    q = 0;
    while (q < n && slot_uses[slot_order[q]] <= slot_uses[e]) q++;
    for (int i = n; i > q; i--) slot_order[i] = slot_order[i - 1];
    slot_order[q] = e;
  endfunction

  // Remove list position p from a list of n entries.
  function automatic void drop_slot(input int n, input int p);
    for (int i = p; i + 1 < n; i++) slot_order[i] = slot_order[i + 1];
  endfunction

  // Apply one operation to the model and return the result it should produce.
  function automatic selection_t predict_selection(input logic [2:0] op,
                                                   input logic [4:0] idx);
    selection_t r;
    int n;
    int p;
    logic [4:0] e;
    r = '0;
    n = slots_held;
    case (op)
      OP_ADD: begin
        if (n >= ENTRIES) begin
          r.status = STAT_BAD;
        end else begin
          slot_uses[n] = '0;
          place_slot(n, 5'(n));
          r.chosen = 5'(n);
          slots_held = n + 1;
        end
      end
      OP_ACQUIRE: begin
        if (n == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          e = slot_order[0];
          drop_slot(n, 0);
          if (slot_uses[e] == COUNT_TOP) r.status = STAT_SAT;
          else slot_uses[e] = slot_uses[e] + 16'd1;
          place_slot(n - 1, e);
          r.chosen = e;
          r.count = slot_uses[e];
        end
      end
      OP_RELEASE: begin
        if (int'(idx) >= n) begin
          r.status = STAT_BAD;
        end else begin
          p = 0;
          while (p < n && slot_order[p] != idx) p++;
          if (p >= n) begin
            r.status = STAT_BAD;
          end else begin
            drop_slot(n, p);
            if (slot_uses[idx] == '0) r.status = STAT_SAT;
            else slot_uses[idx] = slot_uses[idx] - 16'd1;
            place_slot(n - 1, idx);
            r.chosen = idx;
            r.count = slot_uses[idx];
          end
        end
      end
      OP_RESET: begin
        for (int i = 0; i < n; i++) slot_uses[i] = '0;
      end
      OP_CLEAR: begin
        slots_held = 0;
      end
      default: begin
      end
    endcase
    r.held = 6'(slots_held);
    return r;
  endfunction

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_selections.size() == 0) begin
        report_mismatch("result with none pending, status", status, 0);
      end else begin
        oldest_selection = pending_selections.pop_front();
        if (status !== oldest_selection.status)
          report_mismatch("status", status, oldest_selection.status);
        if (chosen_index !== oldest_selection.chosen)
          report_mismatch("chosen_index", chosen_index, oldest_selection.chosen);
        if (use_count !== oldest_selection.count)
          report_mismatch("use_count", use_count, oldest_selection.count);
        if (entry_count !== oldest_selection.held)
          report_mismatch("entry_count", entry_count, oldest_selection.held);
      end
    end
  end

  // Present one item, hold it until the transfer, then record its expectation.
  // Called at a rising edge; typed rows replace the model's result with their own.
  task automatic send_op(input logic [2:0] op, input logic [4:0] idx,
                         input bit typed = 1'b0, input selection_t typed_result = '0);
    selection_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    entry_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_selection(op, idx);
    pending_selections.push_back(typed ? typed_result : predicted);
  endtask

  // Hold the sender off until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_selections.size() != 0) @(posedge clk);
  endtask

  // Random operations, weighted toward acquire and release of held entries.
  task automatic send_random(input int items);
    int done;
    int pick;
    logic [2:0] op;
    logic [4:0] idx;
    done = 0;
    while (done < items) begin
      pick = $urandom_range(0, 99);
      idx = 5'($urandom_range(0, 31));
      if (pick < 22) op = OP_ADD;
      else if (pick < 58) op = OP_ACQUIRE;
      else if (pick < 88) begin
        op = OP_RELEASE;
        if (slots_held > 0 && $urandom_range(0, 9) < 8)
          idx = 5'($urandom_range(0, slots_held - 1));
      end
      else if (pick < 92) op = OP_RESET;
      else if (pick < 95) op = OP_CLEAR;
      else op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
      send_op(op, idx);
      if (op <= OP_CLEAR) done++;
    end
  endtask

  initial begin
    // Directed table: error codes, ignored codes, boundaries and list moves.
    probe_rows.push_back('{OP_ACQUIRE, 5'd0,  1'b1, STAT_EMPTY, 5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_RELEASE, 5'd0,  1'b1, STAT_BAD,   5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_SPARE5,  5'd31, 1'b1, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_SPARE7,  5'd21, 1'b1, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_ADD,     5'd31, 1'b1, STAT_OK,    5'd0, 16'd0, 6'd1});
    probe_rows.push_back('{OP_RELEASE, 5'd0,  1'b1, STAT_SAT,   5'd0, 16'd0, 6'd1});
    probe_rows.push_back('{OP_ACQUIRE, 5'd10, 1'b1, STAT_OK,    5'd0, 16'd1, 6'd1});
    probe_rows.push_back('{OP_ADD,     5'd0,  1'b1, STAT_OK,    5'd1, 16'd0, 6'd2});
    probe_rows.push_back('{OP_ADD,     5'd0,  1'b1, STAT_OK,    5'd2, 16'd0, 6'd3});
    probe_rows.push_back('{OP_ACQUIRE, 5'd0,  1'b0, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_ACQUIRE, 5'd0,  1'b0, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_RELEASE, 5'd31, 1'b1, STAT_BAD,   5'd0, 16'd0, 6'd3});
    probe_rows.push_back('{OP_RELEASE, 5'd3,  1'b1, STAT_BAD,   5'd0, 16'd0, 6'd3});
    probe_rows.push_back('{OP_RELEASE, 5'd2,  1'b0, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_ACQUIRE, 5'd0,  1'b0, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_RESET,   5'd7,  1'b1, STAT_OK,    5'd0, 16'd0, 6'd3});
    probe_rows.push_back('{OP_ACQUIRE, 5'd0,  1'b0, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_RELEASE, 5'd1,  1'b0, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_CLEAR,   5'd0,  1'b1, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_SPARE6,  5'd0,  1'b1, STAT_OK,    5'd0, 16'd0, 6'd0});
    probe_rows.push_back('{OP_ACQUIRE, 5'd0,  1'b1, STAT_EMPTY, 5'd0, 16'd0, 6'd0});

    // Synchronous reset.
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i])
      send_op(probe_rows[i].op, probe_rows[i].idx, probe_rows[i].typed,
              '{probe_rows[i].status, probe_rows[i].chosen,
                probe_rows[i].count, probe_rows[i].held});

    // Fill the list, push once past full, then touch the highest index.
    for (int i = 0; i <= ENTRIES; i++) send_op(OP_ADD, 5'($urandom_range(0, 31)));
    send_op(OP_RELEASE, 5'd31);
    send_op(OP_ACQUIRE, 5'd0);
    send_op(OP_RELEASE, 5'd31);
    drain_results();

    // Step a single entry's count up with repeated acquires, then release it once.
    send_op(OP_CLEAR, 5'd0);
    send_op(OP_ADD, 5'd0);
    for (int k = 0; k < 8; k++)
      send_op(OP_ACQUIRE, 5'($urandom_range(0, 31)));
    send_op(OP_RELEASE, 5'd0);
    send_op(OP_CLEAR, 5'd0);
    drain_results();

    // Random phases with different idling on each side.
    send_idle_pct = 0;  recv_stall_pct = 0;
    send_random(PHASE_ITEMS);
    drain_results();
    send_idle_pct = 61; recv_stall_pct = 0;
    send_random(PHASE_ITEMS);
    send_idle_pct = 0;  recv_stall_pct = 61;
    send_random(PHASE_ITEMS);
    drain_results();
    send_idle_pct = 35; recv_stall_pct = 35;
    send_random(PHASE_ITEMS);

    // Let the last results arrive, then give the verdict.
    drain_results();
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lus_pkg.sv
rtl/lus_ctrl.sv
rtl/lus_datapath.sv
rtl/least_used_slot_selector.sv
tb/sv/least_used_slot_selector_test.sv
